// ===== hdl/can_rx_frame_queue_with_aging_top_macros.svh =====
// ----------------------------------------------------------------------------
// can_rx_frame_queue_with_aging_top_macros
// Assertion shorthands shared by the receive queue modules. Each macro
// expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef CAN_RX_FRAME_QUEUE_WITH_AGING_TOP_MACROS_SVH
`define CAN_RX_FRAME_QUEUE_WITH_AGING_TOP_MACROS_SVH

// Condition holds at every edge outside reset
`define CRFQ_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication
`define CRFQ_ASSERT_IMP(label, ant, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CRFQ_ASSERT_NXT(label, ant, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/crfq_pkg.sv =====
// ----------------------------------------------------------------------------
// crfq_pkg
// Types, codes and sizes for the CAN receive frame queue with aging.
// ----------------------------------------------------------------------------
package crfq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int ID_W    = 29;
  localparam int LEN_W   = 4;
  localparam int PAY_W   = 64;
  localparam int TICK_W  = 32;
  localparam int EVT_W   = 6;
  localparam int CIDX_W  = 4;
  localparam int CNT_W   = 32;
  localparam int CFG_W   = 32;

  localparam logic [LEN_W-1:0]  LEN_MAX       = 4'd8;
  localparam logic [TICK_W-1:0] MAX_AGE_RESET = 32'd1000;

  // Statistics counters
  localparam int NUM_CNT = 10;
  localparam logic [CIDX_W-1:0] CNT_RAW      = 4'd0;
  localparam logic [CIDX_W-1:0] CNT_QUEUED   = 4'd1;
  localparam logic [CIDX_W-1:0] CNT_OVERFLOW = 4'd2;
  localparam logic [CIDX_W-1:0] CNT_LOST     = 4'd3;
  localparam logic [CIDX_W-1:0] CNT_FULL     = 4'd4;
  localparam logic [CIDX_W-1:0] CNT_BUSOFF   = 4'd5;
  localparam logic [CIDX_W-1:0] CNT_WARN     = 4'd6;
  localparam logic [CIDX_W-1:0] CNT_PASSIVE  = 4'd7;
  localparam logic [CIDX_W-1:0] CNT_PROTO    = 4'd8;
  localparam logic [CIDX_W-1:0] CNT_STALE    = 4'd9;

  // Configuration register indexes
  typedef enum logic {
    REG_MAX_AGE  = 1'b0,
    REG_EXT_ONLY = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_EVENT = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_DELIVERED = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_STALE     = 3'd2,
    ST_FILTERED  = 3'd3,
    ST_QUEUED    = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_EVENT     = 3'd6,
    ST_COUNTER   = 3'd7
  } status_e;

  // One stored frame
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic              ext;
    logic [ID_W-1:0]   id;
    logic [PAY_W-1:0]  payload;
    logic [TICK_W-1:0] stamp;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the input item
    logic exec;   // carry out the captured item
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_blocked;  // result register full and stalled
  } sts_t;

endpackage

// ===== hdl/can_rx_frame_queue_with_aging_top.sv =====
// ----------------------------------------------------------------------------
// can_rx_frame_queue_with_aging_top
// Receive queue for one CAN channel: ring of stamped frames with age-based
// drop on pop, standard-id filtering and ten wrapping statistics counters.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-------------------------
//   in       | input     | in_valid_i / in_stall_o | op, frame, tick, flags
//   out      | output    | out_valid_o/out_stall_i | status, frame, counter
//   cfg      | input     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// Each item passes through capture plus registered head-of-queue read,
// then the execute step (age subtract and compare, counter update).
// The result register lets a new item in once the previous result is taken.
// A stalled result blocks further input. Reset clears pointers and counters
// and loads the configuration defaults; no clearing pass of the frame ring is needed.
// ----------------------------------------------------------------------------
module can_rx_frame_queue_with_aging_top import crfq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [ID_W-1:0]    frame_id_i,
  input  logic               frame_extended_i,
  input  logic [LEN_W-1:0]   raw_length_i,
  input  logic [PAY_W-1:0]   frame_payload_i,
  input  logic [TICK_W-1:0]  tick_now_i,
  input  logic [EVT_W-1:0]   event_flags_i,
  input  logic [CIDX_W-1:0]  counter_index_i,
  // configuration port
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [ID_W-1:0]    out_id_o,
  output logic               out_extended_o,
  output logic [LEN_W-1:0]   out_length_o,
  output logic [PAY_W-1:0]   out_payload_o,
  output logic [CNT_W-1:0]   counter_value_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  crfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Queue and counters
  crfq_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .op_i             (op_i),
    .frame_id_i       (frame_id_i),
    .frame_extended_i (frame_extended_i),
    .raw_length_i     (raw_length_i),
    .frame_payload_i  (frame_payload_i),
    .tick_now_i       (tick_now_i),
    .event_flags_i    (event_flags_i),
    .counter_index_i  (counter_index_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .out_id_o         (out_id_o),
    .out_extended_o   (out_extended_o),
    .out_length_o     (out_length_o),
    .out_payload_o    (out_payload_o),
    .counter_value_o  (counter_value_o)
  );

endmodule

// ===== hdl/crfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// crfq_ctrl
// Item sequencer: takes one item, lets the datapath read the queue head,
// then issues the execute step.
// ----------------------------------------------------------------------------
module crfq_ctrl import crfq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;

  // Accept only when idle and the result register will be free
  assign in_stall_o  = (state_q != S_IDLE) || sts_i.out_blocked;
  assign cmd_o.load  = in_valid_i && !in_stall_o;
  assign cmd_o.exec  = (state_q == S_EXEC);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (cmd_o.load) state_d = S_EXEC;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`include "can_rx_frame_queue_with_aging_top_macros.svh"

  `CRFQ_ASSERT_NXT(a_exec_one_cycle, state_q == S_EXEC, state_q == S_IDLE, "exec longer than one cycle")
  `CRFQ_ASSERT_IMP(a_exec_out_free, state_q == S_EXEC, !sts_i.out_blocked, "result register busy at exec")

endmodule

// ===== hdl/crfq_dp.sv =====
// ----------------------------------------------------------------------------
// crfq_dp
// Frame ring, pointers, statistics counters, configuration registers and
// the result register.
// ----------------------------------------------------------------------------
module crfq_dp import crfq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  // input item
  input  logic [1:0]         op_i,
  input  logic [ID_W-1:0]    frame_id_i,
  input  logic               frame_extended_i,
  input  logic [LEN_W-1:0]   raw_length_i,
  input  logic [PAY_W-1:0]   frame_payload_i,
  input  logic [TICK_W-1:0]  tick_now_i,
  input  logic [EVT_W-1:0]   event_flags_i,
  input  logic [CIDX_W-1:0]  counter_index_i,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  // result
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [ID_W-1:0]    out_id_o,
  output logic               out_extended_o,
  output logic [LEN_W-1:0]   out_length_o,
  output logic [PAY_W-1:0]   out_payload_o,
  output logic [CNT_W-1:0]   counter_value_o
);

  // Captured item
  op_e                op_q;
  logic [ID_W-1:0]    id_q;
  logic               ext_q;
  logic [LEN_W-1:0]   len_q;
  logic [PAY_W-1:0]   pay_q;
  logic [TICK_W-1:0]  tick_q;
  logic [EVT_W-1:0]   evt_q;
  logic [CIDX_W-1:0]  cidx_q;

  // Configuration
  logic [TICK_W-1:0]  max_age_q;
  logic               ext_only_q;

  // Queue state
  entry_t             mem_q [QUEUE_DEPTH];
  entry_t             head_q;
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic [CNT_W-1:0]   cnt_q [NUM_CNT];
  logic [NUM_CNT-1:0] cnt_inc;

  // Result register
  logic               out_valid_q, out_valid_d;
  logic [2:0]         status_q, status_d;
  logic [ID_W-1:0]    oid_q, oid_d;
  logic               oext_q, oext_d;
  logic [LEN_W-1:0]   olen_q, olen_d;
  logic [PAY_W-1:0]   opay_q, opay_d;
  logic [CNT_W-1:0]   ocnt_q, ocnt_d;

  logic               is_empty, is_full, do_push, stale;
  logic [TICK_W-1:0]  age;
  entry_t             wr_entry;

  // Item capture; the length code is clamped on the way in
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(op_i);
      id_q   <= frame_id_i;
      ext_q  <= frame_extended_i;
      len_q  <= (raw_length_i > LEN_MAX) ? LEN_MAX : raw_length_i;
      pay_q  <= frame_payload_i;
      tick_q <= tick_now_i;
      evt_q  <= event_flags_i;
      cidx_q <= counter_index_i;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q  <= MAX_AGE_RESET;
      ext_only_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MAX_AGE:  max_age_q  <= cfg_wdata_i;
        REG_EXT_ONLY: ext_only_q <= cfg_wdata_i[0];
        default:      ;
      endcase
    end
  end

  assign is_empty = (occ_q == '0);
  assign is_full  = (occ_q == OCC_W'(QUEUE_DEPTH));
  assign age      = tick_q - head_q.stamp;
  assign stale    = (age > max_age_q);
  assign do_push  = cmd_i.exec && (op_q == OP_PUSH) && !is_full;

  assign wr_entry.len     = len_q;
  assign wr_entry.ext     = ext_q;
  assign wr_entry.id      = id_q;
  assign wr_entry.payload = pay_q;
  assign wr_entry.stamp   = tick_q;

  // Frame ring: one write port, registered read of the head entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_entry;
    end
    head_q <= mem_q[rd_ptr_q];
  end

  // Execute step: pointer moves, counter bumps and the result
  always_comb begin
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    occ_d       = occ_q;
    cnt_inc     = '0;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    oid_d       = oid_q;
    oext_d      = oext_q;
    olen_d      = olen_q;
    opay_d      = opay_q;
    ocnt_d      = ocnt_q;
    if (cmd_i.exec) begin
      out_valid_d = 1'b1;
      oid_d       = '0;
      oext_d      = 1'b0;
      olen_d      = '0;
      opay_d      = '0;
      ocnt_d      = '0;
      case (op_q)
        OP_PUSH: begin
          cnt_inc[CNT_RAW] = 1'b1;
          if (is_full) begin
            cnt_inc[CNT_OVERFLOW] = 1'b1;
            status_d              = ST_OVERFLOW;
          end else begin
            wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
            occ_d    = occ_q + 1'b1;
            cnt_inc[CNT_QUEUED] = 1'b1;
            status_d = ST_QUEUED;
          end
        end
        OP_POP: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
            occ_d    = occ_q - 1'b1;
            if (stale) begin
              cnt_inc[CNT_STALE] = 1'b1;
              status_d           = ST_STALE;
            end else if (ext_only_q && !head_q.ext) begin
              status_d = ST_FILTERED;
            end else begin
              status_d = ST_DELIVERED;
              oid_d    = head_q.id;
              oext_d   = head_q.ext;
              olen_d   = head_q.len;
              opay_d   = head_q.payload;
            end
          end
        end
        OP_EVENT: begin
          cnt_inc[CNT_LOST]    = evt_q[0];
          cnt_inc[CNT_FULL]    = evt_q[1];
          cnt_inc[CNT_BUSOFF]  = evt_q[2];
          cnt_inc[CNT_WARN]    = evt_q[3];
          cnt_inc[CNT_PASSIVE] = evt_q[4];
          cnt_inc[CNT_PROTO]   = evt_q[5];
          status_d             = ST_EVENT;
        end
        OP_READ: begin
          status_d = ST_COUNTER;
          if (cidx_q < CIDX_W'(NUM_CNT)) begin
            ocnt_d = cnt_q[cidx_q];
          end
        end
        default: status_d = ST_EMPTY;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Statistics counters, wrapping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_CNT; i++) begin
        if (cnt_inc[i]) cnt_q[i] <= cnt_q[i] + 1'b1;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    oid_q    <= oid_d;
    oext_q   <= oext_d;
    olen_q   <= olen_d;
    opay_q   <= opay_d;
    ocnt_q   <= ocnt_d;
  end

  assign sts_o.out_blocked = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign out_id_o          = oid_q;
  assign out_extended_o    = oext_q;
  assign out_length_o      = olen_q;
  assign out_payload_o     = opay_q;
  assign counter_value_o   = ocnt_q;

`include "can_rx_frame_queue_with_aging_top_macros.svh"

  `CRFQ_ASSERT(a_occ_bound, occ_q <= OCC_W'(QUEUE_DEPTH), "occupancy above queue depth")
  `CRFQ_ASSERT_NXT(a_rd_ptr_pop_only, !(cmd_i.exec && op_q == OP_POP), $stable(rd_ptr_q), "read pointer moved without pop")
  `CRFQ_ASSERT_NXT(a_result_from_exec, !cmd_i.exec, !$rose(out_valid_q), "result appeared without exec")

endmodule

// ===== dv/can_rx_frame_queue_with_aging_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// can_rx_frame_queue_with_aging_top_test
// Self-checking bench for the CAN receive frame queue. A shadow of the ring,
// its age check, the standard-id filter and the statistics counters predicts
// one result per accepted item. Directed frames cover length clamping, tick
// wrap, the age boundary, empty pops, filtering and out-of-range counter
// reads. Random traffic then alternates push-heavy and pop-heavy runs under
// several register settings and idle patterns, with a long output hold-off
// that backs the queue up into its input.
// ----------------------------------------------------------------------------
module can_rx_frame_queue_with_aging_top_test;
  import crfq_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned FILL_BURST   = QUEUE_DEPTH + 4;
  localparam int unsigned PHASE_ITEMS  = 100;

  // One input item as offered on the input channel
  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   id;
    logic              ext;
    logic [LEN_W-1:0]  raw_len;
    logic [PAY_W-1:0]  payload;
    logic [TICK_W-1:0] tick;
    logic [EVT_W-1:0]  flags;
    logic [CIDX_W-1:0] cidx;
  } rx_item_t;

  // One result as seen on the output channel
  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   id;
    logic              ext;
    logic [LEN_W-1:0]  len;
    logic [PAY_W-1:0]  payload;
    logic [CNT_W-1:0]  counter;
  } rx_result_t;

  // Shadow of the queue, its registers and counters
  class frame_queue_shadow;
    entry_t            ring [QUEUE_DEPTH];
    int unsigned       wr_ptr;
    int unsigned       rd_ptr;
    int unsigned       fill;
    logic [CNT_W-1:0]  stats [NUM_CNT];
    logic [TICK_W-1:0] age_limit;
    logic              ext_only;
    rx_result_t        results_due [$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       status_seen [8];

    function new();
      wr_ptr     = 0;
      rd_ptr     = 0;
      fill       = 0;
      age_limit  = MAX_AGE_RESET;
      ext_only   = 1'b0;
      mismatches = 0;
      checked    = 0;
      foreach (stats[i]) stats[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_MAX_AGE:  age_limit = data;
        REG_EXT_ONLY: ext_only  = data[0];
        default:      ;
      endcase
    endfunction

    // Work out the result of one accepted item and queue it
    function void apply_item(rx_item_t it);
      rx_result_t        res;
      entry_t            e;
      logic [TICK_W-1:0] age;
      int                b;
      res = '0;
      case (it.op)
        OP_PUSH: begin
          // raw count goes up before the full check
          stats[CNT_RAW]++;
          if (fill >= QUEUE_DEPTH) begin
            stats[CNT_OVERFLOW]++;
            res.status = ST_OVERFLOW;
          end else begin
            e.id      = it.id;
            e.ext     = it.ext;
            e.len     = (it.raw_len > LEN_MAX) ? LEN_MAX : it.raw_len;
            e.payload = it.payload;
            e.stamp   = it.tick;
            ring[wr_ptr] = e;
            wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
            fill++;
            stats[CNT_QUEUED]++;
            res.status = ST_QUEUED;
          end
        end
        OP_POP: begin
          if (fill == 0) begin
            res.status = ST_EMPTY;
          end else begin
            e = ring[rd_ptr];
            age = it.tick - e.stamp;  // wraps at 32 bits
            rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
            fill--;
            if (age > age_limit) begin
              stats[CNT_STALE]++;
              res.status = ST_STALE;
            end else if (ext_only && !e.ext) begin
              res.status = ST_FILTERED;
            end else begin
              res.status  = ST_DELIVERED;
              res.id      = e.id;
              res.ext     = e.ext;
              res.len     = e.len;
              res.payload = e.payload;
            end
          end
        end
        OP_EVENT: begin
          // flag bits map onto the counters from lost upward
          for (b = 0; b < EVT_W; b++) begin
            if (it.flags[b]) stats[int'(CNT_LOST) + b]++;
          end
          res.status = ST_EVENT;
        end
        OP_READ: begin
          res.status = ST_COUNTER;
          if (it.cidx < NUM_CNT) res.counter = stats[it.cidx];
        end
        default: ;
      endcase
      results_due.push_back(res);
    endfunction

    function void compare_field(string name, logic [PAY_W-1:0] want, logic [PAY_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Check one result against the oldest prediction
    function void match_result(rx_result_t got);
      rx_result_t want;
      if (results_due.size() == 0) begin
        $error("result with nothing predicted, status %0d", got.status);
        mismatches++;
        return;
      end
      want = results_due.pop_front();
      checked++;
      status_seen[want.status]++;
      compare_field("status", PAY_W'(want.status), PAY_W'(got.status));
      compare_field("out_id", PAY_W'(want.id), PAY_W'(got.id));
      compare_field("out_extended", PAY_W'(want.ext), PAY_W'(got.ext));
      compare_field("out_length", PAY_W'(want.len), PAY_W'(got.len));
      compare_field("out_payload", want.payload, got.payload);
      compare_field("counter_value", PAY_W'(want.counter), PAY_W'(got.counter));
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        op_i;
  logic [ID_W-1:0]   frame_id_i;
  logic              frame_extended_i;
  logic [LEN_W-1:0]  raw_length_i;
  logic [PAY_W-1:0]  frame_payload_i;
  logic [TICK_W-1:0] tick_now_i;
  logic [EVT_W-1:0]  event_flags_i;
  logic [CIDX_W-1:0] counter_index_i;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [CFG_W-1:0]  cfg_wdata_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [2:0]        status_o;
  logic [ID_W-1:0]   out_id_o;
  logic              out_extended_o;
  logic [LEN_W-1:0]  out_length_o;
  logic [PAY_W-1:0]  out_payload_o;
  logic [CNT_W-1:0]  counter_value_o;

  frame_queue_shadow shadow;
  int unsigned       tx_idle_pct;
  int unsigned       rx_idle_pct;
  int unsigned       hold_left;
  int unsigned       cycle_count;
  int unsigned       items_sent;
  int unsigned       settings_used;
  logic [TICK_W-1:0] tick_clock;

  can_rx_frame_queue_with_aging_top dut (.*);

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("can_rx_frame_queue_with_aging_top_test NOT OK");
      $finish;
    end
  end

  // Output side: random stall, long hold-off on request, check each transfer
  initial begin
    rx_result_t got;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
      end
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.status  = status_e'(status_o);
        got.id      = out_id_o;
        got.ext     = out_extended_o;
        got.len     = out_length_o;
        got.payload = out_payload_o;
        got.counter = counter_value_o;
        shadow.match_result(got);
      end
    end
  end

  // Offer one item, with random idle cycles ahead of it, until it transfers
  task automatic send_item(input rx_item_t it);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    op_i             <= it.op;
    frame_id_i       <= it.id;
    frame_extended_i <= it.ext;
    raw_length_i     <= it.raw_len;
    frame_payload_i  <= it.payload;
    tick_now_i       <= it.tick;
    event_flags_i    <= it.flags;
    counter_index_i  <= it.cidx;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    shadow.apply_item(it);
    items_sent++;
  endtask

  // Item with every field random
  function automatic rx_item_t random_fields(op_e op);
    rx_item_t it;
    it.op      = op;
    it.id      = ID_W'($urandom);
    it.ext     = 1'($urandom_range(0, 1));
    it.raw_len = LEN_W'($urandom_range(0, 15));
    it.payload = {$urandom, $urandom};
    it.tick    = $urandom;
    it.flags   = EVT_W'($urandom);
    it.cidx    = CIDX_W'($urandom_range(0, 15));
    return it;
  endfunction

  task automatic push_frame(input logic [ID_W-1:0] id, input logic ext,
                            input logic [LEN_W-1:0] len, input logic [PAY_W-1:0] payload,
                            input logic [TICK_W-1:0] tick);
    rx_item_t it;
    it = random_fields(OP_PUSH);
    it.id      = id;
    it.ext     = ext;
    it.raw_len = len;
    it.payload = payload;
    it.tick    = tick;
    send_item(it);
  endtask

  task automatic pop_frame(input logic [TICK_W-1:0] tick);
    rx_item_t it;
    it = random_fields(OP_POP);
    it.tick = tick;
    send_item(it);
  endtask

  task automatic send_flags(input logic [EVT_W-1:0] flags);
    rx_item_t it;
    it = random_fields(OP_EVENT);
    it.flags = flags;
    send_item(it);
  endtask

  task automatic read_counter(input logic [CIDX_W-1:0] idx);
    rx_item_t it;
    it = random_fields(OP_READ);
    it.cidx = idx;
    send_item(it);
  endtask

  // Random item on a running tick; a few are pure noise
  function automatic rx_item_t next_random(bit push_heavy, int unsigned step_max);
    rx_item_t    it;
    int unsigned r;
    op_e         op;
    r = $urandom_range(0, 99);
    if (push_heavy) op = (r < 78) ? OP_PUSH : (r < 90) ? OP_POP : (r < 95) ? OP_EVENT : OP_READ;
    else            op = (r < 20) ? OP_PUSH : (r < 88) ? OP_POP : (r < 94) ? OP_EVENT : OP_READ;
    it = random_fields(op);
    if ($urandom_range(0, 99) < 4) return it;
    tick_clock = tick_clock + $urandom_range(0, step_max);
    if ($urandom_range(0, 99) == 0) tick_clock = tick_clock + $urandom;
    it.tick = tick_clock;
    if (!it.ext) it.id = {18'b0, it.id[10:0]};  // standard ids carry 11 bits
    if ($urandom_range(0, 4) != 0) it.cidx = CIDX_W'($urandom_range(0, NUM_CNT - 1));
    return it;
  endfunction

  task automatic run_random(input int unsigned n_items, input int unsigned step_max,
                            input bit with_pressure);
    int unsigned k;
    int unsigned left_in_run;
    bit          push_heavy;
    push_heavy  = 1'b1;
    left_in_run = $urandom_range(10, 45);
    for (k = 0; k < n_items; k++) begin
      if (left_in_run == 0) begin
        push_heavy  = !push_heavy;
        left_in_run = $urandom_range(10, 45);
      end
      left_in_run--;
      // long output hold-off while input keeps coming
      if (with_pressure && k == n_items / 3) hold_left = 250;
      send_item(next_random(push_heavy, step_max));
    end
  endtask

  // Drop valid and wait for every predicted result
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (shadow.results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    shadow.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // New register setting; upper bits of the filter write are don't-care
  task automatic configure(input logic [TICK_W-1:0] age, input logic ext);
    logic [CFG_W-1:0] data;
    wait_idle();
    write_reg(REG_MAX_AGE, age);
    data    = $urandom;
    data[0] = ext;
    write_reg(REG_EXT_ONLY, data);
    settings_used++;
  endtask

  // Stimulus
  initial begin
    rx_item_t it;
    int       k;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    op_i             = OP_PUSH;
    frame_id_i       = '0;
    frame_extended_i = 1'b0;
    raw_length_i     = '0;
    frame_payload_i  = '0;
    tick_now_i       = '0;
    event_flags_i    = '0;
    counter_index_i  = '0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = REG_MAX_AGE;
    cfg_wdata_i      = '0;
    out_stall_i      = 1'b0;
    hold_left        = 0;
    items_sent       = 0;
    settings_used    = 1;
    tick_clock       = '0;
    shadow           = new();
    tx_idle_pct      = 33;
    rx_idle_pct      = 57;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset registers, empty pop, odd counter indexes
    pop_frame('0);
    read_counter(4'd15);
    read_counter(4'd10);
    // field extremes, clamped lengths
    push_frame('1, 1'b1, 4'd15, '1, '1);
    push_frame('0, 1'b0, 4'd0, '0, '0);
    push_frame(29'h7FF, 1'b0, LEN_MAX, 64'h0123_4567_89AB_CDEF, 32'd10);
    push_frame(29'h1234_5678, 1'b1, 4'd9, {$urandom, $urandom}, 32'd100);
    // age across tick wrap, exactly at the limit, one past it
    pop_frame(32'd5);
    pop_frame(32'd1000);
    pop_frame(32'd1011);
    pop_frame(32'd1100);
    pop_frame(32'd1100);
    // flags: none, all, lowest, highest
    send_flags(6'h3F);
    send_flags(6'h00);
    send_flags(6'h01);
    send_flags(6'h20);
    read_counter(CNT_RAW);
    read_counter(CNT_QUEUED);
    read_counter(CNT_STALE);
    read_counter(CNT_LOST);
    read_counter(CNT_PROTO);
    // standard-id filter with no age limit
    configure('1, 1'b1);
    push_frame(29'h123, 1'b0, 4'd3, {$urandom, $urandom}, 32'd5);
    push_frame(29'h1ABC_DEF, 1'b1, 4'd8, {$urandom, $urandom}, 32'd0);
    pop_frame(32'd0);
    pop_frame(32'd3);

    // Random: fill past full, then mixed runs per setting
    configure('0, 1'b0);
    tick_clock = $urandom;
    for (k = 0; k < FILL_BURST; k++) begin
      it = next_random(1'b1, 1);
      it.op = OP_PUSH;
      send_item(it);
    end
    run_random(PHASE_ITEMS - FILL_BURST, 1, 1'b0);
    configure($urandom_range(0, 300), 1'b1);
    run_random(PHASE_ITEMS, 20, 1'b0);

    tx_idle_pct = 57;
    rx_idle_pct = 33;
    configure('1, 1'b0);
    tick_clock = 32'hFFFF_F000;
    run_random(PHASE_ITEMS, 60, 1'b0);
    configure(MAX_AGE_RESET, 1'b1);
    run_random(PHASE_ITEMS, 60, 1'b0);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure($urandom, 1'b0);
    tick_clock = $urandom;
    run_random(PHASE_ITEMS, 60, 1'b0);
    configure(32'd800, 1'b0);
    run_random(PHASE_ITEMS, 50, 1'b1);
    configure(32'd1000, 1'b1);
    run_random(PHASE_ITEMS, 40, 1'b0);

    wait_idle();
    $display("%0d items sent, %0d results checked under %0d register settings",
             items_sent, shadow.checked, settings_used);
    $display("delivered %0d, stale %0d, filtered %0d, empty %0d, overflow %0d, reads %0d",
             shadow.status_seen[ST_DELIVERED], shadow.status_seen[ST_STALE],
             shadow.status_seen[ST_FILTERED], shadow.status_seen[ST_EMPTY],
             shadow.status_seen[ST_OVERFLOW], shadow.status_seen[ST_COUNTER]);
    if (shadow.mismatches == 0) begin
      $display("can_rx_frame_queue_with_aging_top_test OK");
    end else begin
      $display("can_rx_frame_queue_with_aging_top_test NOT OK");
    end
    $finish;
  end

endmodule
